>>> rtl/rpi_pkg.sv
package rpi_pkg;

  // Hit distances are unsigned Q16.16-style words of fixed width
  localparam int HIT_W   = 32;
  localparam int QUADS   = 4;
  localparam int TOL_W   = 16;
  localparam int CFG_AW  = 3;

  // Output tdata: four hits then the valid mask, padded to bytes
  localparam int OUT_RAW_W  = QUADS * HIT_W + QUADS;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Register index codes (paddr bit 2)
  localparam logic REG_HEIGHT = 1'b0;
  localparam logic REG_TOL    = 1'b1;

endpackage

>>> rtl/rpi_div_stage.sv
module rpi_div_stage
  import rpi_pkg::*;
#(
  parameter int NW = 34
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NW-1:0]     rem_i,
  input  logic [HIT_W-1:0]  q_i,
  input  logic [NW-1:0]     den_i,
  output logic [NW-1:0]     rem_o,
  output logic [HIT_W-1:0]  q_o,
  output logic [NW-1:0]     den_o
);

  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          ge;
  logic [NW-1:0] rem_nxt;

  // One restoring step: bring in the next dividend bit, try to subtract
  always_comb begin
    trial   = {rem_i, q_i[HIT_W-1]};
    diff    = trial - {1'b0, den_i};
    ge      = (trial >= {1'b0, den_i});
    rem_nxt = ge ? diff[NW-1:0] : trial[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      q_o   <= {q_i[HIT_W-2:0], ge};
      den_o <= den_i;
    end
  end

endmodule

>>> rtl/rpi_side_check.sv
module rpi_side_check
  import rpi_pkg::*;
#(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] p_i,
  input  logic signed [CW-1:0] d_i,
  input  logic [HIT_W-1:0]     t_i,
  output logic                 pos_o
);

  localparam int MW = CW + HIT_W;

  logic [CW-1:0] mag_p;
  logic [CW-1:0] mag_d;
  logic [MW-1:0] am_r;
  logic [MW-1:0] bm_r;
  logic          an_r;
  logic          bn_r;

  always_comb begin
    mag_p = p_i[CW-1] ? (~p_i + 1'b1) : p_i;
    mag_d = d_i[CW-1] ? (~d_i + 1'b1) : d_i;
  end

  // Multiply stage: |p|<<frac and |d|*t
  always_ff @(posedge clk) begin
    if (en) begin
      am_r <= MW'(mag_p) << FB;
      bm_r <= MW'(mag_d) * MW'(t_i);
      an_r <= p_i[CW-1];
      bn_r <= d_i[CW-1];
    end
  end

  // Sign of p*2^frac + d*t, strictly positive
  always_comb begin
    if (!an_r && !bn_r)    pos_o = (am_r | bm_r) != '0;
    else if (an_r && bn_r) pos_o = 1'b0;
    else if (an_r)         pos_o = bm_r > am_r;
    else                   pos_o = am_r > bm_r;
  end

endmodule

>>> rtl/ray_pyramid_intersect.sv
// Throughput: one ray per cycle while the result side is not stalled; a
//   32-stage restoring divider per quadrant, one quotient bit per stage,
//   sets the depth.
// A stall on the result side holds the whole pipeline in place.
// Reset (rst_n low, synchronous) clears all valid bits; height returns
//   to 1.0 and zero_tolerance to 1.
module ray_pyramid_intersect
  import rpi_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest first)
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit_pp, hit_np, hit_pn, hit_nn, hit_valid (lowest first)
  output logic [OUT_DATA_W-1:0]           out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [CFG_AW-1:0]               cfg_paddr,
  input  logic [(COORD_WIDTH>32 ? 64 : 32)-1:0] cfg_pwdata,
  output logic [(COORD_WIDTH>32 ? 64 : 32)-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int DW  = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int NW  = CW + 2;
  localparam int SH  = HIT_W - FB;
  localparam int EW  = NW + HIT_W;
  localparam int NST = HIT_W + 4;

  // Configuration registers
  logic signed [CW-1:0] height_r;
  logic [TOL_W-1:0]     tol_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= CW'(1) << FB;
      tol_r    <= TOL_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_HEIGHT: height_r <= cfg_pwdata[CW-1:0];
        REG_TOL:    tol_r    <= cfg_pwdata[TOL_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_HEIGHT: cfg_prdata = DW'(height_r);
      REG_TOL:    cfg_prdata = DW'(tol_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Pipeline advance and valid bits
  logic           en;
  logic [NST-1:0] vld_r;

  assign en         = !vld_r[NST-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // Input fields
  logic signed [CW-1:0] px, py, pz, dx, dy, dz;
  assign px = in_tdata[0*CW +: CW];
  assign py = in_tdata[1*CW +: CW];
  assign pz = in_tdata[2*CW +: CW];
  assign dx = in_tdata[3*CW +: CW];
  assign dy = in_tdata[4*CW +: CW];
  assign dz = in_tdata[5*CW +: CW];

  // Stage A: numerator and denominator per quadrant
  logic signed [NW-1:0] num_nxt [QUADS];
  logic signed [NW-1:0] den_nxt [QUADS];
  logic signed [NW-1:0] num_a_r [QUADS];
  logic signed [NW-1:0] den_a_r [QUADS];
  logic signed [CW-1:0] px_a_r, py_a_r, dx_a_r, dy_a_r;

  always_comb begin
    for (int q = 0; q < QUADS; q++) begin
      num_nxt[q] = NW'(height_r) - NW'(pz)
                 - (q[0] ? -NW'(px) : NW'(px))
                 - (q[1] ? -NW'(py) : NW'(py));
      den_nxt[q] = NW'(dz)
                 + (q[0] ? -NW'(dx) : NW'(dx))
                 + (q[1] ? -NW'(dy) : NW'(dy));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_a_r <= num_nxt;
      den_a_r <= den_nxt;
      px_a_r  <= px;
      py_a_r  <= py;
      dx_a_r  <= dx;
      dy_a_r  <= dy;
    end
  end

  // Divider stage arrays; index 0 is stage B
  logic [NW-1:0]        rem_s [QUADS][HIT_W+1];
  logic [HIT_W-1:0]     quo_s [QUADS][HIT_W+1];
  logic [NW-1:0]        dvs_s [QUADS][HIT_W+1];
  logic [QUADS-1:0]     go_s  [HIT_W+1];
  logic [QUADS-1:0]     sat_s [HIT_W+1];
  logic signed [CW-1:0] px_s  [HIT_W+1];
  logic signed [CW-1:0] py_s  [HIT_W+1];
  logic signed [CW-1:0] dx_s  [HIT_W+1];
  logic signed [CW-1:0] dy_s  [HIT_W+1];

  // Stage B: magnitudes, zero test, sign test, saturation, first remainder
  logic [NW-1:0] mag_n [QUADS];
  logic [NW-1:0] mag_d [QUADS];
  logic [EW-1:0] dvd   [QUADS];
  logic [QUADS-1:0] go_nxt, sat_nxt;
  logic [NW-1:0]    rem_b_r [QUADS];
  logic [HIT_W-1:0] quo_b_r [QUADS];
  logic [NW-1:0]    dvs_b_r [QUADS];

  always_comb begin
    for (int q = 0; q < QUADS; q++) begin
      mag_n[q]   = num_a_r[q][NW-1] ? NW'(-num_a_r[q]) : NW'(num_a_r[q]);
      mag_d[q]   = den_a_r[q][NW-1] ? NW'(-den_a_r[q]) : NW'(den_a_r[q]);
      go_nxt[q]  = (mag_d[q] > NW'(tol_r)) &&
                   ((num_a_r[q] == '0) || (num_a_r[q][NW-1] == den_a_r[q][NW-1]));
      sat_nxt[q] = EW'(mag_n[q]) >= (EW'(mag_d[q]) << SH);
      dvd[q]     = EW'(mag_n[q]) << FB;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int q = 0; q < QUADS; q++) begin
        rem_b_r[q] <= (go_nxt[q] && !sat_nxt[q]) ? dvd[q][EW-1:HIT_W] : '0;
        quo_b_r[q] <= dvd[q][HIT_W-1:0];
        dvs_b_r[q] <= mag_d[q];
      end
      go_s[0]  <= go_nxt;
      sat_s[0] <= sat_nxt;
      px_s[0]  <= px_a_r;
      py_s[0]  <= py_a_r;
      dx_s[0]  <= dx_a_r;
      dy_s[0]  <= dy_a_r;
      // Sideband travels with the divider
      for (int k = 1; k <= HIT_W; k++) begin
        go_s[k]  <= go_s[k-1];
        sat_s[k] <= sat_s[k-1];
        px_s[k]  <= px_s[k-1];
        py_s[k]  <= py_s[k-1];
        dx_s[k]  <= dx_s[k-1];
        dy_s[k]  <= dy_s[k-1];
      end
    end
  end

  // Divider: one quotient bit per stage, four lanes
  for (genvar q = 0; q < QUADS; q++) begin : g_lane
    assign rem_s[q][0] = rem_b_r[q];
    assign quo_s[q][0] = quo_b_r[q];
    assign dvs_s[q][0] = dvs_b_r[q];
    for (genvar k = 0; k < HIT_W; k++) begin : g_step
      rpi_div_stage #(.NW(NW)) u_step (
        .clk   (clk),
        .en    (en),
        .rem_i (rem_s[q][k]),
        .q_i   (quo_s[q][k]),
        .den_i (dvs_s[q][k]),
        .rem_o (rem_s[q][k+1]),
        .q_o   (quo_s[q][k+1]),
        .den_o (dvs_s[q][k+1])
      );
    end
  end

  // Saturated distance, then side checks (multiply stage inside)
  logic [HIT_W-1:0] t_d   [QUADS];
  logic [HIT_W-1:0] t_m_r [QUADS];
  logic [QUADS-1:0] go_m_r;
  logic [QUADS-1:0] posx, posy;

  always_comb begin
    for (int q = 0; q < QUADS; q++) begin
      t_d[q] = sat_s[HIT_W][q] ? '1 : quo_s[q][HIT_W];
    end
  end

  for (genvar q = 0; q < QUADS; q++) begin : g_side
    rpi_side_check #(.CW(CW), .FB(FB)) u_sx (
      .clk (clk), .en (en), .p_i (px_s[HIT_W]), .d_i (dx_s[HIT_W]),
      .t_i (t_d[q]), .pos_o (posx[q])
    );
    rpi_side_check #(.CW(CW), .FB(FB)) u_sy (
      .clk (clk), .en (en), .p_i (py_s[HIT_W]), .d_i (dy_s[HIT_W]),
      .t_i (t_d[q]), .pos_o (posy[q])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_m_r  <= t_d;
      go_m_r <= go_s[HIT_W];
    end
  end

  // Output stage: quadrant sign match, zero invalid hits
  logic [QUADS-1:0] ok;
  logic [HIT_W-1:0] hit_r [QUADS];
  logic [QUADS-1:0] hit_valid_r;

  always_comb begin
    for (int q = 0; q < QUADS; q++) begin
      ok[q] = go_m_r[q] && (posx[q] != q[0]) && (posy[q] != q[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int q = 0; q < QUADS; q++) begin
        hit_r[q] <= ok[q] ? t_m_r[q] : '0;
      end
      hit_valid_r <= ok;
    end
  end

  assign out_tdata = OUT_DATA_W'({hit_valid_r, hit_r[3], hit_r[2], hit_r[1], hit_r[0]});

  // Checks
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  a_invalid_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[QUADS*HIT_W] |-> out_tdata[HIT_W-1:0] == '0)
    else $error("invalid hit carries a distance");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rpi_pkg::*;

  localparam int CW       = 32;
  localparam int FB       = 16;
  localparam int IN_W     = ((6 * CW + 7) / 8) * 8;
  localparam int LATENCY  = HIT_W + 4;
  localparam int WD_LIMIT = 20000;
  localparam logic [CFG_AW-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_TOL    = {REG_TOL, 2'b00};

  typedef struct packed {
    logic [3:0]  valid;
    logic [31:0] nn;
    logic [31:0] pn;
    logic [31:0] np;
    logic [31:0] pp;
  } hits_t;

  // Expected hit sets, computed from the ray and the current pyramid setup
  class hit_scoreboard;
    hits_t pending[$];
    logic signed [63:0] apex;
    logic [63:0] tol;
    int errors;
    int checked;

    function new();
      apex = 65536;
      tol = 1;
      errors = 0;
      checked = 0;
    endfunction

    function logic [63:0] mag(logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    // p*2^FB + d*t > 0, exact (128-bit)
    function bit side_pos(logic signed [63:0] p, logic signed [63:0] d, logic [63:0] t);
      logic signed [127:0] a;
      logic signed [127:0] b;
      a = p <<< FB;
      b = d * $signed({64'd0, t});
      return (a + b) > 0;
    endfunction

    function void note_ray(logic [IN_W-1:0] ray);
      logic signed [63:0] px, py, pz, dx, dy, dz, num, den;
      logic [63:0] t;
      hits_t h;
      bit xn, yn, ok;
      px = $signed(ray[31:0]);
      py = $signed(ray[63:32]);
      pz = $signed(ray[95:64]);
      dx = $signed(ray[127:96]);
      dy = $signed(ray[159:128]);
      dz = $signed(ray[191:160]);
      h = '0;
      for (int q = 0; q < QUADS; q++) begin
        xn = q[0];
        yn = q[1];
        num = apex - pz - (xn ? -px : px) - (yn ? -py : py);
        den = dz + (xn ? -dx : dx) + (yn ? -dy : dy);
        t = 0;
        ok = 0;
        if (mag(den) > tol && (num == 0 || ((num < 0) == (den < 0)))) begin
          t = (mag(num) << FB) / mag(den);
          if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
          ok = (side_pos(px, dx, t) != xn) && (side_pos(py, dy, t) != yn);
        end
        if (!ok) t = 0;
        h.valid[q] = ok;
        case (q)
          0: h.pp = t[31:0];
          1: h.np = t[31:0];
          2: h.pn = t[31:0];
          default: h.nn = t[31:0];
        endcase
      end
      pending.insert(pending.size(), h);
    endfunction

    function void check_hits(hits_t got);
      hits_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: valid %h/%h pp %h/%h np %h/%h pn %h/%h nn %h/%h",
                   checked, want.valid, got.valid, want.pp, got.pp, want.np, got.np,
                   want.pn, got.pn, want.nn, got.nn);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  hit_scoreboard sb = new();
  int idle_cycles = 0;
  int rays_sent = 0;
  bit long_hold = 0;
  bit rx_run = 0;

  always #5 clk = ~clk;

  ray_pyramid_intersect dut (.*);

  // Score accepted rays and results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_ray(in_tdata);
      if (out_tvalid && out_tready) sb.check_hits(hits_t'(out_tdata[OUT_RAW_W-1:0]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rx_run)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int w;
    @(posedge clk);
    wait (rx_run);
    forever begin
      if (long_hold) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 2) == 0) w = 0;
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    if (addr == ADDR_HEIGHT) sb.apex = $signed(data);
    else sb.tol = data[TOL_W-1:0];
  endtask

  task automatic send_ray(logic [IN_W-1:0] ray, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 16) : 0;
    if (gaps && $urandom_range(0, 2) == 0) w = 0;
    if (w > 0) begin
      in_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= ray;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rays_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
  endfunction

  // Ray mostly aimed near the apex so that real hits show up
  function automatic logic [IN_W-1:0] rand_ray();
    logic [31:0] f[6];
    logic [IN_W-1:0] r;
    for (int i = 0; i < 6; i++) f[i] = coord();
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 3; i++) f[i] = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      for (int i = 3; i < 6; i++) f[i] = $signed($urandom_range(0, 2 << 16)) - (1 << 16);
      if ($urandom_range(0, 4) == 0) f[$urandom_range(3, 5)] = $urandom_range(0, 3);
    end
    r = '0;
    for (int i = 0; i < 6; i++) r[32*i +: 32] = f[i];
    return r;
  endfunction

  function automatic logic [IN_W-1:0] mk_ray(logic [31:0] px, py, pz, dx, dy, dz);
    logic [IN_W-1:0] r;
    r = '0;
    r[191:0] = {dz, dy, dx, pz, py, px};
    return r;
  endfunction

  initial begin
    logic [31:0] heights[4];
    logic [31:0] tols[4];
    heights = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_8000};
    tols = '{16'd1, 16'd0, 16'hFFFF, 16'h0100};

    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    rx_run = 1;

    // Directed: axis rays, zero den, negative t, saturation, extremes
    send_ray(mk_ray(0, 0, 32'h0002_0000, 0, 0, 32'hFFFF_0000), 0);
    send_ray(mk_ray(32'h0000_8000, 32'h0000_8000, 0, 0, 0, 32'h0001_0000), 0);
    send_ray(mk_ray(32'hFFFF_8000, 32'h0000_4000, 32'h0003_0000, 0, 0, 32'hFFFF_0000), 0);
    send_ray(mk_ray(32'h0000_4000, 32'hFFFF_C000, 32'h0003_0000, 0, 0, 32'hFFFF_0000), 0);
    send_ray(mk_ray(32'hFFFF_C000, 32'hFFFF_C000, 32'h0003_0000, 0, 0, 32'hFFFF_0000), 0);
    send_ray(mk_ray(0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000), 0);
    send_ray(mk_ray(0, 0, 0, 0, 0, 32'h0000_0001), 0);
    send_ray(mk_ray(0, 0, 0, 0, 0, 32'h0000_0002), 0);
    send_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
    send_ray(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
    send_ray(mk_ray(0, 0, 32'h8000_0000, 0, 0, 32'h0000_0003), 0);
    send_ray(mk_ray(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000), 0);
    send_ray(mk_ray('1, '1, '1, '1, '1, '1), 0);
    send_ray(mk_ray(0, 0, 0, 0, 0, 0), 0);
    drain();

    // Random phases over register settings
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(ADDR_HEIGHT, ph < 4 ? heights[ph] : $urandom);
      cfg_write(ADDR_TOL, ph < 4 ? tols[ph] : $urandom_range(0, 65535));
      for (int i = 0; i < 215; i++) begin
        if (ph == 2 && i == 20) long_hold = 1;
        send_ray(rand_ray(), (i % 60) < 45);
      end
      drain();
    end
    cfg_write(ADDR_HEIGHT, 32'h0001_0000);
    cfg_write(ADDR_TOL, 32'd1);
    for (int i = 0; i < 30; i++) send_ray(rand_ray(), 1);
    drain();

    $display("covered %0d rays over 9 height/tolerance settings, %0d results checked",
             rays_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
